/* rtl/one_shot_voice_mixer_macros.svh */
// ---------------------------------------------------------------------------
// one_shot_voice_mixer_macros.svh
// Assertion shorthands for the voice mixer; clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef ONE_SHOT_VOICE_MIXER_MACROS_SVH
`define ONE_SHOT_VOICE_MIXER_MACROS_SVH

// Same-cycle implication.
`define OSVM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OSVM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/osvm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osvm_pkg
// Shared types and constants of the one-shot voice mixer.
// ---------------------------------------------------------------------------
package osvm_pkg;

    // Default sizing
    localparam int MAX_VOICES_DEF    = 8;
    localparam int CLIP_DEPTH_DEF    = 4096;
    localparam int SCALE_DIVISOR_DEF = 4;

    localparam int NUM_CLIPS  = 5;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 3;

    // Valid clip numbers
    localparam logic [2:0] CLIP_FIRST = 3'd1;
    localparam logic [2:0] CLIP_LAST  = 3'd5;

    // Command codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         clip;
        logic [11:0]        sample_index;
        logic signed [15:0] sample_value;
    } cmd_t;

    typedef struct packed {
        logic [15:0] mix;
        logic [3:0]  active_voices;
        logic        accepted;
    } result_t;

endpackage

/* rtl/one_shot_voice_mixer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// one_shot_voice_mixer
// Polyphonic one-shot sample player: clip store, voice table and mix engine.
// ---------------------------------------------------------------------------
// A word is taken on cmd when start is high and busy is low, and each word
// gives exactly one result word on result, marked by result_valid for one
// cycle; the receiver cannot stall, so it must take every result as it
// comes. Load, trigger and the unused code leave busy low and show their
// result in the next cycle, so these words can be issued back to back. A
// tick walks the voice table one voice per cycle and holds busy high until
// the last voice has drained: one voice-table read per voice, then the
// sample read, the scaling multiply and the accumulate drain behind the
// last voice. The single voice-table read port sets that pace. The sample
// store is not cleared; a sample must be loaded before any voice plays it.
// Clip lengths are written through the cfg port (always ready); the user
// must write them only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------

`include "one_shot_voice_mixer_macros.svh"

module one_shot_voice_mixer #(
    parameter int MAX_VOICES    = osvm_pkg::MAX_VOICES_DEF,
    parameter int CLIP_DEPTH    = osvm_pkg::CLIP_DEPTH_DEF,
    parameter int SCALE_DIVISOR = osvm_pkg::SCALE_DIVISOR_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  osvm_pkg::cmd_t                 cmd,
    // result channel
    output logic                           result_valid,
    output osvm_pkg::result_t              result,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [osvm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [osvm_pkg::LEN_W-1:0]     cfg_data
);

    // -----------------------------------------------------------------------
    // Derived sizes
    // -----------------------------------------------------------------------
    localparam int VW   = ($clog2(MAX_VOICES) > 0) ? $clog2(MAX_VOICES) : 1;
    localparam int CNW  = $clog2(MAX_VOICES + 1);
    localparam int PW   = $clog2(CLIP_DEPTH + 1);       // position, up to CLIP_DEPTH
    localparam int CW   = (PW > osvm_pkg::LEN_W) ? PW : osvm_pkg::LEN_W;
    localparam int IW   = (PW > 12) ? PW : 12;
    localparam int SDEPTH = osvm_pkg::NUM_CLIPS * CLIP_DEPTH;
    localparam int AW   = $clog2(SDEPTH);

    // Division by SCALE_DIVISOR as multiply by a rounded-up reciprocal.
    // With a 16-bit magnitude and a 20-bit shift the quotient is exact for
    // every divisor up to 16.
    localparam int RSH          = 20;
    localparam int RW           = RSH + 1;
    localparam int RECIP_INT    = ((1 << RSH) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;
    localparam logic [RW-1:0] RECIP = RW'(RECIP_INT);
    localparam int PRW          = 16 + RW;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TICK = 2'b10
    } state_t;

    typedef struct packed {
        logic [2:0]    clip_idx;   // clip number minus one
        logic [PW-1:0] pos;
    } voice_t;

    // -----------------------------------------------------------------------
    // Memories
    // -----------------------------------------------------------------------
    logic [15:0] smem [SDEPTH];
    voice_t      vmem [MAX_VOICES];

    logic          smem_we;
    logic [AW-1:0] smem_waddr;
    logic [15:0]   smem_wdata;
    logic [AW-1:0] smem_raddr;
    logic [15:0]   smem_rdata_reg;

    logic          vmem_we;
    logic [VW-1:0] vmem_waddr;
    voice_t        vmem_wdata;
    logic [VW-1:0] vmem_raddr;
    voice_t        vmem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            smem[smem_waddr] <= smem_wdata;
        end
        smem_rdata_reg <= smem[smem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vmem_we)
        begin
            vmem[vmem_waddr] <= vmem_wdata;
        end
        vmem_rdata_reg <= vmem[vmem_raddr];
    end

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    state_t                   state_reg, state_next;
    logic [CNW-1:0]           rd_cnt_reg, rd_cnt_next;
    logic [MAX_VOICES-1:0]    busy_reg, busy_next;
    logic [osvm_pkg::LEN_W-1:0] clip_len_reg [osvm_pkg::NUM_CLIPS];
    logic [osvm_pkg::LEN_W-1:0] clip_len_next [osvm_pkg::NUM_CLIPS];

    // stage B: voice entry back from the table
    logic          b_vld_reg, b_vld_next;
    logic          b_last_reg, b_last_next;
    logic [VW-1:0] b_idx_reg, b_idx_next;
    // stage C: sample back from the store
    logic          c_vld_reg, c_vld_next;
    logic          c_last_reg, c_last_next;
    logic          c_play_reg, c_play_next;
    // stage D: scaled magnitude
    logic          d_vld_reg, d_vld_next;
    logic          d_last_reg, d_last_next;
    logic          d_play_reg, d_play_next;
    logic          d_neg_reg, d_neg_next;
    logic [15:0]   d_q_reg, d_q_next;

    logic [15:0]       acc_reg, acc_next;
    logic              res_valid_reg, res_valid_next;
    osvm_pkg::result_t res_reg, res_next;

    // -----------------------------------------------------------------------
    // Combinational helpers
    // -----------------------------------------------------------------------
    logic                       take;
    logic                       take_tick;
    logic                       clip_ok;
    logic                       idx_ok;
    logic [2:0]                 cmd_clip_idx;
    logic                       free_any;
    logic [VW-1:0]              free_idx;
    logic                       issue;
    logic                       b_busy;
    logic [osvm_pkg::LEN_W-1:0] b_len;
    logic                       b_in_range;
    logic [15:0]                c_mag;
    logic [PRW-1:0]             c_prod;
    logic [15:0]                d_term;

    assign take         = start && (state_reg == S_IDLE);
    assign take_tick    = take && (cmd.op == osvm_pkg::OP_TICK);
    assign clip_ok      = cmd.clip inside {[osvm_pkg::CLIP_FIRST : osvm_pkg::CLIP_LAST]};
    assign idx_ok       = IW'(cmd.sample_index) < IW'(CLIP_DEPTH);
    assign cmd_clip_idx = 3'(cmd.clip - 3'd1);

    // lowest free voice
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int v = MAX_VOICES - 1; v >= 0; v--)
        begin
            if (!busy_reg[v])
            begin
                free_any = 1'b1;
                free_idx = VW'(v);
            end
        end
    end

    assign issue = (state_reg == S_TICK) && (rd_cnt_reg < CNW'(MAX_VOICES));

    // stage B: is the voice still inside its clip?
    assign b_busy     = busy_reg[b_idx_reg];
    assign b_len      = clip_len_reg[vmem_rdata_reg.clip_idx];
    assign b_in_range = (CW'(vmem_rdata_reg.pos) < CW'(b_len)) &&
                        (CW'(vmem_rdata_reg.pos) < CW'(CLIP_DEPTH));

    // stage C: magnitude times reciprocal
    assign c_mag  = smem_rdata_reg[15] ? 16'(16'd0 - smem_rdata_reg) : smem_rdata_reg;
    assign c_prod = PRW'(c_mag) * PRW'(RECIP);

    // stage D: signed contribution, wraps in 16 bits
    assign d_term = !d_play_reg ? 16'd0 :
                    (d_neg_reg ? 16'(16'd0 - d_q_reg) : d_q_reg);

    assign smem_raddr = AW'(AW'(vmem_rdata_reg.clip_idx) * AW'(CLIP_DEPTH)
                            + AW'(vmem_rdata_reg.pos));
    assign smem_waddr = AW'(AW'(cmd_clip_idx) * AW'(CLIP_DEPTH) + AW'(cmd.sample_index));
    assign smem_wdata = cmd.sample_value;
    assign vmem_raddr = rd_cnt_reg[VW-1:0];

    // -----------------------------------------------------------------------
    // Next-state logic
    // -----------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        busy_next      = busy_reg;
        clip_len_next  = clip_len_reg;
        acc_next       = acc_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        smem_we    = 1'b0;
        vmem_we    = 1'b0;
        vmem_waddr = b_idx_reg;
        vmem_wdata = vmem_rdata_reg;

        // configuration writes; beyond the list they are dropped
        if (cfg_valid && (cfg_index < osvm_pkg::CFG_IDX_W'(osvm_pkg::NUM_CLIPS)))
        begin
            clip_len_next[cfg_index] = cfg_data;
        end

        // voice read issue
        b_vld_next  = issue;
        b_last_next = issue && (rd_cnt_reg == CNW'(MAX_VOICES - 1));
        b_idx_next  = rd_cnt_reg[VW-1:0];
        if (issue)
        begin
            rd_cnt_next = CNW'(rd_cnt_reg + 1'b1);
        end

        // stage B: advance a playing voice or free a spent one
        c_vld_next  = b_vld_reg;
        c_last_next = b_last_reg;
        c_play_next = b_vld_reg && b_busy && b_in_range;
        if (b_vld_reg && b_busy)
        begin
            if (b_in_range)
            begin
                vmem_we        = 1'b1;
                vmem_wdata.pos = PW'(vmem_rdata_reg.pos + PW'(1));
            end
            else
            begin
                busy_next[b_idx_reg] = 1'b0;
            end
        end

        // stage C
        d_vld_next  = c_vld_reg;
        d_last_next = c_last_reg;
        d_play_next = c_vld_reg && c_play_reg;
        d_neg_next  = smem_rdata_reg[15];
        d_q_next    = c_prod[RSH +: 16];

        // stage D: accumulate, close the tick on the last voice
        if (d_vld_reg)
        begin
            acc_next = 16'(acc_reg + d_term);
            if (d_last_reg)
            begin
                res_valid_next         = 1'b1;
                res_next.mix           = 16'(acc_reg + d_term);
                res_next.active_voices = 4'($countones(busy_reg));
                res_next.accepted      = 1'b0;
                state_next             = S_IDLE;
            end
        end

        // new command word
        if (take)
        begin
            case (cmd.op)
                osvm_pkg::OP_TICK:
                begin
                    state_next  = S_TICK;
                    rd_cnt_next = '0;
                    acc_next    = '0;
                end
                osvm_pkg::OP_TRIGGER:
                begin
                    res_valid_next    = 1'b1;
                    res_next.mix      = '0;
                    res_next.accepted = clip_ok && free_any;
                    if (clip_ok && free_any)
                    begin
                        busy_next[free_idx] = 1'b1;
                        vmem_we             = 1'b1;
                        vmem_waddr          = free_idx;
                        vmem_wdata.clip_idx = cmd_clip_idx;
                        vmem_wdata.pos      = '0;
                    end
                    res_next.active_voices = 4'($countones(busy_next));
                end
                osvm_pkg::OP_LOAD:
                begin
                    smem_we                = clip_ok && idx_ok;
                    res_valid_next         = 1'b1;
                    res_next.mix           = '0;
                    res_next.accepted      = 1'b0;
                    res_next.active_voices = 4'($countones(busy_reg));
                end
                default:
                begin
                    // unused code: no effect
                    res_valid_next         = 1'b1;
                    res_next.mix           = '0;
                    res_next.accepted      = 1'b0;
                    res_next.active_voices = 4'($countones(busy_reg));
                end
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Control registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            busy_reg      <= '0;
            b_vld_reg     <= 1'b0;
            b_last_reg    <= 1'b0;
            c_vld_reg     <= 1'b0;
            c_last_reg    <= 1'b0;
            c_play_reg    <= 1'b0;
            d_vld_reg     <= 1'b0;
            d_last_reg    <= 1'b0;
            d_play_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < osvm_pkg::NUM_CLIPS; i++)
            begin
                clip_len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            busy_reg      <= busy_next;
            b_vld_reg     <= b_vld_next;
            b_last_reg    <= b_last_next;
            c_vld_reg     <= c_vld_next;
            c_last_reg    <= c_last_next;
            c_play_reg    <= c_play_next;
            d_vld_reg     <= d_vld_next;
            d_last_reg    <= d_last_next;
            d_play_reg    <= d_play_next;
            res_valid_reg <= res_valid_next;
            clip_len_reg  <= clip_len_next;
        end
    end

    // -----------------------------------------------------------------------
    // Data registers
    // -----------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        b_idx_reg <= b_idx_next;
        d_neg_reg <= d_neg_next;
        d_q_reg   <= d_q_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    // -----------------------------------------------------------------------
    // Outputs
    // -----------------------------------------------------------------------
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `OSVM_ASSERT_IMP(a_result_idle, result_valid, !busy, "result shown while busy")
    `OSVM_ASSERT_NXT(a_tick_busy, take_tick, busy, "tick did not start")
    `OSVM_ASSERT_NXT(a_quick_result, take && !take_tick, result_valid && !busy, "no quick result")
    `OSVM_ASSERT_IMP(a_drained, !busy, !(b_vld_reg || c_vld_reg || d_vld_reg), "not drained")

endmodule

/* bench/tb_one_shot_voice_mixer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_one_shot_voice_mixer
// Self-checking bench for the one-shot voice mixer.
// ---------------------------------------------------------------------------
// A cycle-free predictor keeps its own clip store, voice table and clip
// lengths. Each command word that the mixer takes is run through it, and
// the expected result word is queued. Every result word is then checked
// field by field against the oldest entry in the queue. A short scripted
// run covers the corner cases. Random phases with fresh clip lengths and
// random idle gaps follow. Before every tick the bench loads any sample
// that a playing voice is about to read, so no unwritten store entry is
// ever played.
// ---------------------------------------------------------------------------

module tb_one_shot_voice_mixer;

    localparam int VOICES     = osvm_pkg::MAX_VOICES_DEF;
    localparam int CLIP_DEPTH = osvm_pkg::CLIP_DEPTH_DEF;
    localparam int DIVISOR    = osvm_pkg::SCALE_DIVISOR_DEF;
    localparam int STORE_SIZE = osvm_pkg::NUM_CLIPS * CLIP_DEPTH;

    // Command code with no function; the mixer must answer it with zeros
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Clip length register map
    localparam logic [osvm_pkg::CFG_IDX_W-1:0] REG_CLIP1_LEN = 3'd0;
    localparam logic [osvm_pkg::CFG_IDX_W-1:0] REG_CLIP2_LEN = 3'd1;
    localparam logic [osvm_pkg::CFG_IDX_W-1:0] REG_CLIP3_LEN = 3'd2;
    localparam logic [osvm_pkg::CFG_IDX_W-1:0] REG_CLIP4_LEN = 3'd3;
    localparam logic [osvm_pkg::CFG_IDX_W-1:0] REG_CLIP5_LEN = 3'd4;

    localparam int WORD_TARGET = 1775;    // scripted words plus about 1750 random
    localparam int TIMEOUT_NS  = 10_000_000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    osvm_pkg::cmd_t                 cmd;
    logic                           result_valid;
    osvm_pkg::result_t              result;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [osvm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [osvm_pkg::LEN_W-1:0]     cfg_data;

    one_shot_voice_mixer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // -----------------------------------------------------------------------
    // Predictor state: its own copy of the clip store, voices and lengths
    // -----------------------------------------------------------------------
    logic [osvm_pkg::LEN_W-1:0] clip_len       [osvm_pkg::NUM_CLIPS];
    logic                       voice_on       [VOICES];
    logic [2:0]                 voice_clip_no  [VOICES];
    logic [12:0]                voice_pos      [VOICES];
    logic signed [15:0]         sample_mem     [STORE_SIZE];
    bit                         sample_written [STORE_SIZE];

    osvm_pkg::result_t pending_results [$];   // expected result words, oldest first
    int                words_sent;
    int                fails;
    bit                gaps_on;

    function automatic bit clip_valid(input logic [2:0] c);
        return c >= osvm_pkg::CLIP_FIRST && c <= osvm_pkg::CLIP_LAST;
    endfunction

    // Lengths beyond the clip depth play as a full clip
    function automatic int eff_len(input logic [2:0] c);
        int len;
        if (!clip_valid(c))
            return 0;
        len = clip_len[int'(c) - 1];
        return (len > CLIP_DEPTH) ? CLIP_DEPTH : len;
    endfunction

    function automatic int store_addr(input logic [2:0] c, input int pos);
        return (int'(c) - 1) * CLIP_DEPTH + pos;
    endfunction

    // Applies one command word to the predictor and gives its result word
    function automatic osvm_pkg::result_t mix_predict(input osvm_pkg::cmd_t w);
        osvm_pkg::result_t r;
        logic [15:0]       mix_sum;
        int                scaled_val;
        int                addr;
        int                n_busy;
        r       = '0;
        mix_sum = '0;
        n_busy  = 0;
        case (w.op)
            osvm_pkg::OP_TICK:
                for (int v = 0; v < VOICES; v++) begin
                    if (voice_on[v]) begin
                        if (voice_pos[v] < eff_len(voice_clip_no[v])) begin
                            addr       = store_addr(voice_clip_no[v], int'(voice_pos[v]));
                            // signed divide truncates toward zero
                            scaled_val = int'(sample_mem[addr]) / DIVISOR;
                            mix_sum    = mix_sum + 16'(scaled_val);
                            voice_pos[v] = voice_pos[v] + 1'b1;
                        end
                        else begin
                            // ran out: freed on this tick, adds nothing
                            voice_on[v]      = 1'b0;
                            voice_clip_no[v] = '0;
                            voice_pos[v]     = '0;
                        end
                    end
                end
            osvm_pkg::OP_TRIGGER:
                if (clip_valid(w.clip)) begin
                    for (int v = 0; v < VOICES; v++) begin
                        if (!voice_on[v]) begin
                            voice_on[v]      = 1'b1;
                            voice_clip_no[v] = w.clip;
                            voice_pos[v]     = '0;
                            r.accepted       = 1'b1;
                            break;
                        end
                    end
                end
            osvm_pkg::OP_LOAD:
                if (clip_valid(w.clip) && int'(w.sample_index) < CLIP_DEPTH) begin
                    addr                 = store_addr(w.clip, int'(w.sample_index));
                    sample_mem[addr]     = w.sample_value;
                    sample_written[addr] = 1'b1;
                end
            default: ;
        endcase
        for (int v = 0; v < VOICES; v++)
            if (voice_on[v])
                n_busy++;
        r.mix           = mix_sum;
        r.active_voices = 4'(n_busy);
        return r;
    endfunction

    // Queues one expected result word behind the others
    function automatic void add_expected(input osvm_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // -----------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so every strobe is a word
    // -----------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        osvm_pkg::result_t want;
        if (rst_n && result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: mix %h voices %0d acc %0d",
                       result.mix, result.active_voices, result.accepted);
                fails++;
            end
            else begin
                want = pending_results.pop_front();
                if (result.mix !== want.mix) begin
                    $error("mix: expected %h, got %h", want.mix, result.mix);
                    fails++;
                end
                if (result.active_voices !== want.active_voices) begin
                    $error("active_voices: expected %0d, got %0d",
                           want.active_voices, result.active_voices);
                    fails++;
                end
                if (result.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
                    fails++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Drivers: inputs move on the falling edge, handshakes are seen on the
    // rising edge
    // -----------------------------------------------------------------------

    // Presents one word and holds it until taken. A scripted row may carry
    // its own expected result; the predictor still runs to keep its state.
    task automatic send_word(input osvm_pkg::cmd_t w, input bit typed,
                             input osvm_pkg::result_t typed_res);
        osvm_pkg::result_t predicted;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        forever begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predicted = mix_predict(w);
        add_expected(typed ? typed_res : predicted);
        words_sent++;
    endtask

    function automatic osvm_pkg::cmd_t random_word();
        osvm_pkg::cmd_t w;
        w.op           = 2'($urandom_range(0, 3));
        w.clip         = 3'($urandom_range(0, 7));
        w.sample_index = 12'($urandom_range(0, 4095));
        w.sample_value = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    // Mostly back to back or short gaps, now and then a long one that
    // can span a whole tick
    task automatic idle_gap();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = 0;
        if (gaps_on) begin
            if (k >= 90)
                n = $urandom_range(6, 40);
            else if (k >= 55)
                n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= random_word();
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Loads every sample that the next tick will play but that was never
    // written
    task automatic fill_playing_samples();
        osvm_pkg::cmd_t w;
        int             addr;
        for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v] && voice_pos[v] < eff_len(voice_clip_no[v])) begin
                addr = store_addr(voice_clip_no[v], int'(voice_pos[v]));
                if (!sample_written[addr]) begin
                    w              = random_word();
                    w.op           = osvm_pkg::OP_LOAD;
                    w.clip         = voice_clip_no[v];
                    w.sample_index = 12'(voice_pos[v]);
                    send_word(w, 1'b0, '0);
                    idle_gap();
                end
            end
        end
    endtask

    task automatic issue(input osvm_pkg::cmd_t w, input bit typed,
                         input osvm_pkg::result_t typed_res);
        if (w.op == osvm_pkg::OP_TICK)
            fill_playing_samples();
        send_word(w, typed, typed_res);
        idle_gap();
    endtask

    task automatic write_length(input logic [osvm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [osvm_pkg::LEN_W-1:0] len);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= len;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        clip_len[idx - REG_CLIP1_LEN] = len;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop issuing and wait until every result word is in and the mixer
    // is idle, so the lengths may change
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Mostly short clips so voices come and go; now and then empty, full,
    // one short of full, or longer than the clip depth (clamped)
    function automatic logic [osvm_pkg::LEN_W-1:0] pick_length();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0:       return '0;
            1:       return 13'd4096;
            2:       return 13'd8191;
            3:       return 13'($urandom_range(4097, 8190));
            4:       return 13'd4095;
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [2:0] bad_clip();
        int k;
        k = $urandom_range(0, 2);
        return (k == 0) ? 3'd0 : 3'(k + 5);
    endfunction

    // Mostly well-formed traffic on valid clips, a tenth noise
    function automatic osvm_pkg::cmd_t random_command();
        osvm_pkg::cmd_t w;
        int             k;
        int             len;
        w = random_word();
        k = $urandom_range(0, 99);
        if (k < 45) begin
            w.op = osvm_pkg::OP_TICK;
        end
        else if (k < 70) begin
            w.op   = osvm_pkg::OP_TRIGGER;
            w.clip = 3'($urandom_range(osvm_pkg::CLIP_FIRST, osvm_pkg::CLIP_LAST));
        end
        else if (k < 90) begin
            w.op   = osvm_pkg::OP_LOAD;
            w.clip = 3'($urandom_range(osvm_pkg::CLIP_FIRST, osvm_pkg::CLIP_LAST));
            len    = eff_len(w.clip);
            if (len > 0 && $urandom_range(0, 3) != 0)
                w.sample_index = 12'($urandom_range(0, len - 1));
        end
        else begin
            case ($urandom_range(0, 2))
                0: begin w.op = osvm_pkg::OP_TRIGGER; w.clip = bad_clip(); end
                1: begin w.op = osvm_pkg::OP_LOAD;    w.clip = bad_clip(); end
                default: w.op = OP_UNUSED;
            endcase
        end
        return w;
    endfunction

    // -----------------------------------------------------------------------
    // Scripted opening run. Lengths on entry: clip 1 two samples, clip 2
    // one, clip 3 empty, clip 4 full, clip 5 over the clip depth. Expected
    // words are typed in where obvious; the rest go through the predictor.
    // -----------------------------------------------------------------------
    typedef struct packed {
        osvm_pkg::cmd_t    w;
        bit                typed;
        osvm_pkg::result_t res;
    } script_row_t;

    localparam int SCRIPT_LEN = 25;

    script_row_t script [SCRIPT_LEN] = '{
        // idle after reset, unused code, bad triggers and bad loads: all zero
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{OP_UNUSED,            3'd7, 12'hFFF, 16'hFFFF}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd0, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd6, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd7, 12'hFFF, 16'hFFFF}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_LOAD,    3'd0, 12'h123, 16'h1234}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_LOAD,    3'd7, 12'hFFF, 16'h8000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        // full-scale samples, and one that scales to zero toward zero
        '{'{osvm_pkg::OP_LOAD,    3'd1, 12'h000, 16'h7FFF}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_LOAD,    3'd1, 12'h001, 16'h8000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_LOAD,    3'd2, 12'h000, 16'hFFFD}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        // empty clip: voice starts, then frees on the next tick adding nothing
        '{'{osvm_pkg::OP_TRIGGER, 3'd3, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd1, 1'b1}},
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd0, 1'b0}},
        // fill all eight voices
        '{'{osvm_pkg::OP_TRIGGER, 3'd1, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd2, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd5, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd4, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd1, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd2, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd3, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TRIGGER, 3'd1, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        // every voice busy: trigger dropped
        '{'{osvm_pkg::OP_TRIGGER, 3'd2, 12'h000, 16'h0000}, 1'b1, '{16'h0000, 4'd8, 1'b0}},
        // play out: short clips run out and free, long ones keep going
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}},
        '{'{osvm_pkg::OP_TICK,    3'd0, 12'h000, 16'h0000}, 1'b0, '{16'h0000, 4'd0, 1'b0}}
    };

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        int n_words;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        words_sent = 0;
        fails      = 0;
        gaps_on    = 1'b1;
        for (int c = 0; c < osvm_pkg::NUM_CLIPS; c++)
            clip_len[c] = '0;
        for (int v = 0; v < VOICES; v++) begin
            voice_on[v]      = 1'b0;
            voice_clip_no[v] = '0;
            voice_pos[v]     = '0;
        end
        for (int a = 0; a < STORE_SIZE; a++) begin
            sample_mem[a]     = '0;
            sample_written[a] = 1'b0;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every register once, with the extremes of the length range
        write_length(REG_CLIP1_LEN, 13'd2);
        write_length(REG_CLIP2_LEN, 13'd1);
        write_length(REG_CLIP3_LEN, 13'd0);
        write_length(REG_CLIP4_LEN, 13'd4096);
        write_length(REG_CLIP5_LEN, 13'd8191);

        for (int i = 0; i < SCRIPT_LEN; i++)
            issue(script[i].w, script[i].typed, script[i].res);

        // random phases, each with fresh lengths; voices left playing carry
        // over, so a shortened clip frees them on the next tick
        while (words_sent < WORD_TARGET) begin
            settle();
            for (int k = 0; k < osvm_pkg::NUM_CLIPS; k++)
                write_length(REG_CLIP1_LEN + 3'(k), pick_length());
            gaps_on = ($urandom_range(0, 3) != 0);
            n_words = $urandom_range(120, 200);
            repeat (n_words) issue(random_command(), 1'b0, '0);
        end

        settle();
        // a stray word would show within one tick time
        repeat (VOICES + 8) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
